/* sv/eucd_pkg.sv */
package eucd_pkg;

  // result kinds as seen on the cell channel
  typedef enum logic [1:0] {
    KIND_UNIT      = 2'd0,
    KIND_INVALID   = 2'd1,
    KIND_LEAD      = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_t;

  // decoder phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_WANT_U = 2'd1,
    PH_HEX    = 2'd2,
    PH_CONT   = 2'd3
  } phase_t;

  localparam logic [7:0] CHAR_DOT       = 8'h2E;
  localparam logic [7:0] CHAR_CARET     = 8'h5E;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U         = 8'h75;

  localparam logic [2:0] HEX_DIGITS     = 3'd4;
  localparam logic [2:0] CONT_TWO_BYTE  = 3'd1;
  localparam logic [2:0] CONT_THREE_BYTE = 3'd2;

  localparam logic [15:0] UNIT_ESC_INVALID = 16'hFFFF;
  localparam logic [15:0] MIN_TWO_BYTE     = 16'h0080;
  localparam logic [15:0] MIN_THREE_BYTE   = 16'h0800;
  localparam logic [15:0] SURROGATE_LO     = 16'hD800;
  localparam logic [15:0] SURROGATE_HI     = 16'hE000;

  // one decoded cell plus its valid flag
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [15:0] unit;
  } result_t;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] d;
    d = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = 5'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = 5'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = 5'(b - 8'h57);
    end
    return d;
  endfunction

endpackage

/* sv/eucd_if.sv */
interface eucd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source(output valid, in_byte, last_byte, input ready);
  modport sink(input valid, in_byte, last_byte, output ready);
endinterface

interface eucd_cell_if import eucd_pkg::*;;
  logic        valid;
  logic        ready;
  kind_t       cell_kind;
  logic [15:0] code_unit;

  modport source(output valid, cell_kind, code_unit, input ready);
  modport sink(input valid, cell_kind, code_unit, output ready);
endinterface

/* sv/eucd_in_reg.sv */
module eucd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       take,
  output logic       ready,
  output logic       valid,
  output logic [7:0] held_byte,
  output logic       held_last
);

  assign ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      held_byte <= in_byte;
      held_last <= in_last;
    end
  end

endmodule

/* sv/eucd_decode.sv */
module eucd_decode import eucd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [2:0]  remaining, remaining_next;
  logic        three_byte, three_byte_next;
  logic [15:0] acc, acc_next;

  logic [4:0]  digit;
  logic [15:0] hex_v;
  logic [15:0] cont_v;
  logic        fail;
  logic        bad_utf8;

  always_comb begin
    digit    = hex_value(in_byte);
    hex_v    = {acc[11:0], digit[3:0]};
    cont_v   = {acc[9:0], in_byte[5:0]};
    bad_utf8 = (!three_byte && cont_v < MIN_TWO_BYTE) ||
               (three_byte && cont_v < MIN_THREE_BYTE) ||
               (cont_v >= SURROGATE_LO && cont_v < SURROGATE_HI);

    phase_next      = phase;
    remaining_next  = remaining;
    three_byte_next = three_byte;
    acc_next        = acc;
    res             = '{valid: 1'b0, kind: KIND_UNIT, unit: 16'h0000};
    fail            = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (in_byte == CHAR_DOT) begin
          res = '{valid: 1'b1, kind: KIND_INVALID, unit: 16'h0000};
        end else if (in_byte == CHAR_CARET) begin
          res = '{valid: 1'b1, kind: KIND_LEAD, unit: 16'h0000};
        end else if (in_byte == CHAR_BACKSLASH) begin
          if (last_byte) fail = 1'b1;
          else phase_next = PH_WANT_U;
        end else if (!in_byte[7]) begin
          res = '{valid: 1'b1, kind: KIND_UNIT, unit: {8'h00, in_byte}};
        end else if (in_byte[7:5] == 3'b110) begin
          if (last_byte) begin
            fail = 1'b1;
          end else begin
            phase_next      = PH_CONT;
            remaining_next  = CONT_TWO_BYTE;
            three_byte_next = 1'b0;
            acc_next        = {11'h000, in_byte[4:0]};
          end
        end else if (in_byte[7:4] == 4'b1110) begin
          if (last_byte) begin
            fail = 1'b1;
          end else begin
            phase_next      = PH_CONT;
            remaining_next  = CONT_THREE_BYTE;
            three_byte_next = 1'b1;
            acc_next        = {12'h000, in_byte[3:0]};
          end
        end else begin
          fail = 1'b1;
        end
      end
      PH_WANT_U: begin
        if (in_byte != CHAR_U || last_byte) begin
          fail = 1'b1;
        end else begin
          phase_next     = PH_HEX;
          remaining_next = HEX_DIGITS;
          acc_next       = 16'h0000;
        end
      end
      PH_HEX: begin
        if (digit[4]) begin
          fail = 1'b1;
        end else if (remaining <= 3'd1) begin
          phase_next      = PH_IDLE;
          remaining_next  = 3'd0;
          three_byte_next = 1'b0;
          acc_next        = 16'h0000;
          if (hex_v == UNIT_ESC_INVALID)
            res = '{valid: 1'b1, kind: KIND_INVALID, unit: 16'h0000};
          else
            res = '{valid: 1'b1, kind: KIND_UNIT, unit: hex_v};
        end else if (last_byte) begin
          fail = 1'b1;
        end else begin
          acc_next       = hex_v;
          remaining_next = remaining - 3'd1;
        end
      end
      PH_CONT: begin
        if (in_byte[7:6] != 2'b10) begin
          fail = 1'b1;
        end else if (remaining <= 3'd1) begin
          phase_next      = PH_IDLE;
          remaining_next  = 3'd0;
          three_byte_next = 1'b0;
          acc_next        = 16'h0000;
          if (bad_utf8)
            res = '{valid: 1'b1, kind: KIND_MALFORMED, unit: 16'h0000};
          else
            res = '{valid: 1'b1, kind: KIND_UNIT, unit: cont_v};
        end else if (last_byte) begin
          fail = 1'b1;
        end else begin
          acc_next       = cont_v;
          remaining_next = remaining - 3'd1;
        end
      end
      default: begin
        fail = 1'b1;
      end
    endcase

    // malformed input drops back to idle
    if (fail) begin
      phase_next      = PH_IDLE;
      remaining_next  = 3'd0;
      three_byte_next = 1'b0;
      acc_next        = 16'h0000;
      res             = '{valid: 1'b1, kind: KIND_MALFORMED, unit: 16'h0000};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      remaining  <= 3'd0;
      three_byte <= 1'b0;
      acc        <= 16'h0000;
    end else if (step) begin
      phase      <= phase_next;
      remaining  <= remaining_next;
      three_byte <= three_byte_next;
      acc        <= acc_next;
    end
  end

endmodule

/* sv/eucd_out_reg.sv */
module eucd_out_reg import eucd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  input  logic        out_ready,
  output logic        free,
  output logic        valid,
  output kind_t       kind,
  output logic [15:0] unit
);

  assign free = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      kind <= res.kind;
      unit <= res.unit;
    end
  end

endmodule

/* sv/escaped_utf8_cell_decoder_top.sv */
// escaped utf-8 cell decoder
//
// bytes: input channel, one raw text byte per transfer (in_byte) with
//   last_byte marking the final byte of a text run
// cells: output channel, one decoded cell per transfer: cell_kind is code
//   unit, invalid-sequence marker, lead-byte marker or malformed, and
//   code_unit carries the bmp value for a code unit (zero otherwise)
// a byte that only advances an escape or a multi-byte sequence gives no
//   cell; a malformed byte gives a malformed cell and the decoder restarts
//   at idle with the next byte
// path: an accepted byte is held in the input register, then decoded
//   into the output register, which presents its cell
// throughput: one byte per cycle while the cell channel does not stall,
//   set by the decode step that updates the phase, count and partial value registers
// stall: when cells.ready is low the output register holds its cell; the
//   input register still fills, and bytes.ready drops once both are full
// reset: rst is synchronous; both registers empty and the decoder idle
module escaped_utf8_cell_decoder_top import eucd_pkg::*; (
  input logic        clk,
  input logic        rst,
  eucd_byte_if.sink  bytes,
  eucd_cell_if.source cells
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_last;
  logic       out_free;
  logic       step;
  result_t    res;

  // the held byte is decoded when the result register can take its cell
  assign step = held_valid && out_free;

  eucd_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bytes.valid),
    .in_byte   (bytes.in_byte),
    .in_last   (bytes.last_byte),
    .take      (step),
    .ready     (bytes.ready),
    .valid     (held_valid),
    .held_byte (held_byte),
    .held_last (held_last)
  );

  // decode state only moves on a step
  eucd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_byte   (held_byte),
    .last_byte (held_last),
    .res       (res)
  );

  eucd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res.valid),
    .res       (res),
    .out_ready (cells.ready),
    .free      (out_free),
    .valid     (cells.valid),
    .kind      (cells.cell_kind),
    .unit      (cells.code_unit)
  );

endmodule
